// ===== sv/sic_pkg.sv =====
// Shared types and constants for the stream inversion counter.
// No dependencies; imported by every module of the block.
package sic_pkg;

    // Fixed field widths of the request and result ports
    localparam int SAMPLE_W  = 32;
    localparam int GREATER_W = 9;
    localparam int TOTAL_W   = 32;
    // Widest supported value; samples are sign-extended to this first
    localparam int EXT_W     = 64;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_LEN     = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // Control bits that travel with each request down the cell chain
    typedef struct packed {
        logic valid;   // stage holds a request
        logic last;    // request ends its sequence
        logic stored;  // some earlier cell took the key
    } t_ctl;

endpackage

// ===== sv/sic_cell.sv =====
// One cell of the compare chain: holds one stored key and passes requests on.
// Depends on sic_pkg (t_ctl).
module sic_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]       i_cnt,
    input  sic_pkg::t_ctl          i_ctl,
    output logic [VALUE_WIDTH-1:0] o_key,
    output logic [CNT_W-1:0]       o_cnt,
    output sic_pkg::t_ctl          o_ctl
);
    import sic_pkg::*;

    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_full;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]       r_cnt;
    t_ctl                   r_ctl;

    logic                   hit;
    logic                   take;
    logic [CNT_W-1:0]       n_cnt;
    t_ctl                   n_ctl;

    // Compare against the held key; claim this cell if it is empty
    always_comb begin
        hit          = r_full && (r_val > i_key);
        take         = i_ctl.valid && !r_full && !i_ctl.stored;
        n_cnt        = i_cnt + CNT_W'(hit);
        n_ctl        = i_ctl;
        n_ctl.stored = i_ctl.stored | take;
    end

    // Control: stage valid and cell occupancy; a last request empties the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_full <= 1'b0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
            if (i_ctl.valid && i_ctl.last) begin
                r_full <= 1'b0;
            end else if (take) begin
                r_full <= 1'b1;
            end
        end
    end

    // Payload: forwarded key and count, stored key
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key <= i_key;
            r_cnt <= n_cnt;
            if (take) begin
                r_val <= i_key;
            end
        end
    end

    assign o_key = r_key;
    assign o_cnt = r_cnt;
    assign o_ctl = r_ctl;

endmodule

// ===== sv/sic_tail.sv =====
// End of the chain: saturating total, sticky overflow and the result register.
// Depends on sic_pkg (t_ctl, field widths).
module sic_tail #(
    parameter int CNT_W = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [CNT_W-1:0]                i_cnt,
    input  sic_pkg::t_ctl                   i_ctl,
    input  logic                            i_stall,
    output logic                            o_adv,
    output logic                            o_valid,
    output logic [sic_pkg::GREATER_W-1:0]   o_greater_before,
    output logic [sic_pkg::TOTAL_W-1:0]     o_running_total,
    output logic                            o_overflow,
    output logic                            o_done_res
);
    import sic_pkg::*;

    logic                 r_valid;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_ovf;
    logic [GREATER_W-1:0] r_greater;
    logic [TOTAL_W-1:0]   r_run;
    logic                 r_ovf_out;
    logic                 r_done;

    logic [TOTAL_W:0]     sum;
    logic [TOTAL_W-1:0]   n_total;
    logic                 n_ovf;
    logic                 take;

    // Chain moves whenever the result register is free or being drained
    assign o_adv = !r_valid || !i_stall;
    assign take  = o_adv && i_ctl.valid;

    // Saturating add; a request no cell took means the store was full
    always_comb begin
        sum     = {1'b0, r_total} + (TOTAL_W + 1)'(i_cnt);
        n_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        n_ovf   = r_ovf | !i_ctl.stored;
    end

    // Sequence state and result valid; clear the sequence after a last request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_ctl.valid;
            if (i_ctl.valid) begin
                if (i_ctl.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_greater <= GREATER_W'(i_cnt);
            r_run     <= n_total;
            r_ovf_out <= n_ovf;
            r_done    <= i_ctl.last;
        end
    end

    assign o_valid          = r_valid;
    assign o_greater_before = r_greater;
    assign o_running_total  = r_run;
    assign o_overflow       = r_ovf_out;
    assign o_done_res       = r_done;

endmodule

// ===== sv/stream_inversion_counter.sv =====
// Top level of the streaming inversion counter: a chain of compare cells
// followed by the total and result stage. Depends on sic_pkg, sic_cell, sic_tail.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one sample and a last flag per
//   request. Output channel (o_valid / i_stall) returns one result per
//   request, in order: the count of earlier stored samples of the sequence
//   that are strictly greater, the saturating running total, the sticky
//   overflow flag and a copy of last.
//   Each of the MAX_LEN cells holds one stored sample. A request walks the
//   chain one cell per cycle unless stalled; the first empty cell keeps it,
//   and every full cell adds one to its count when its key is greater. A last
//   request empties each cell as it passes, so the next sequence starts clean.
//   Throughput: one request per cycle while the output is not stalled.
//   Path: an accepted request is registered in cell 0, then in each following
//   cell in order, and last in the result register.
//   Stall: while i_stall holds a pending result, the whole chain freezes
//   and o_stall is raised; nothing is dropped.
//   Reset: synchronous, active low; empties every cell, clears the stage
//   valid bits, the total and the overflow flag. No clearing pass needed.
module stream_inversion_counter #(
    parameter int MAX_LEN     = sic_pkg::DEF_MAX_LEN,
    parameter int VALUE_WIDTH = sic_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [sic_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_last,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [sic_pkg::GREATER_W-1:0]          o_greater_before,
    output logic [sic_pkg::TOTAL_W-1:0]            o_running_total,
    output logic                                   o_overflow,
    output logic                                   o_done_res
);
    import sic_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [EXT_W-1:0]       sample_ext;
    logic [VALUE_WIDTH-1:0] key_in;
    logic                   adv;

    logic [VALUE_WIDTH-1:0] chain_key [MAX_LEN+1];
    logic [CNT_W-1:0]       chain_cnt [MAX_LEN+1];
    t_ctl                   chain_ctl [MAX_LEN+1];

    // Sign-extend, keep the low bits, flip the sign so unsigned order matches
    assign sample_ext = {{(EXT_W - SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign key_in     = sample_ext[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    // Feed the head of the chain
    assign chain_key[0]        = key_in;
    assign chain_cnt[0]        = '0;
    assign chain_ctl[0].valid  = i_valid;
    assign chain_ctl[0].last   = i_last;
    assign chain_ctl[0].stored = 1'b0;

    assign o_stall = !adv;

    // Compare cells, one stored sample each
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        sic_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_key   (chain_key[g]),
            .i_cnt   (chain_cnt[g]),
            .i_ctl   (chain_ctl[g]),
            .o_key   (chain_key[g+1]),
            .o_cnt   (chain_cnt[g+1]),
            .o_ctl   (chain_ctl[g+1])
        );
    end

    // Total, overflow and result register
    sic_tail #(
        .CNT_W (CNT_W)
    ) u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cnt            (chain_cnt[MAX_LEN]),
        .i_ctl            (chain_ctl[MAX_LEN]),
        .i_stall          (i_stall),
        .o_adv            (adv),
        .o_valid          (o_valid),
        .o_greater_before (o_greater_before),
        .o_running_total  (o_running_total),
        .o_overflow       (o_overflow),
        .o_done_res       (o_done_res)
    );

endmodule
